// File: sv/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg: shared types and constants for the indexed ordered list
// Request and response formats, sizes, and the command and status
// interface between the controller and the datapath.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int Capacity   = 64;
  localparam int AddrWidth  = $clog2(Capacity);
  localparam int CountWidth = $clog2(Capacity + 1);
  localparam int PosWidth   = 7;
  localparam int WordWidth  = 32;

  typedef enum logic [2:0] {
    CMD_INSERT_AT  = 3'd0,
    CMD_REMOVE_AT  = 3'd1,
    CMD_GET_AT     = 3'd2,
    CMD_PUSH_FRONT = 3'd3,
    CMD_PUSH_BACK  = 3'd4,
    CMD_POP_FRONT  = 3'd5,
    CMD_POP_BACK   = 3'd6,
    CMD_CLEAR      = 3'd7
  } command_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    command_e               command;
    logic [PosWidth-1:0]    position;
    logic [WordWidth-1:0]   data_in;
  } iol_req_t;

  typedef struct packed {
    status_e                status;
    logic [WordWidth-1:0]   data_out;
    logic [CountWidth-1:0]  element_count;
    logic [WordWidth-1:0]   front_word;
    logic [WordWidth-1:0]   back_word;
  } iol_rsp_t;

  // Port A read address source
  typedef enum logic [2:0] {
    RD_POS,      // effective position of the request
    RD_POS_INC,  // one past the effective position
    RD_TOP,      // last stored word
    RD_DN,       // index minus one
    RD_UP,       // index plus one
    RD_ZERO      // front word
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,       // move word read at index to index plus one
    WR_DN,       // move word read at index to index minus one
    WR_WORD      // store request word at effective position
  } wr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_POS_INC,
    IDX_DEC,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  typedef struct packed {
    logic    load_req;
    logic    stat_load;
    logic    got_load;
    logic    rsp_load;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    idx_op_e idx_op;
    cnt_op_e cnt_op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_ins;
    logic is_clr;
    logic is_get;
    logic err;
    logic ins_at_end;
    logic rem_last;
    logic idx_at_pos;
    logic idx_at_top;
  } dp_sts_t;

endpackage

// File: sv/iol_datapath.sv
// ----------------------------------------------------------------------------
// iol_datapath: slot memory, count, shift index and response register
// Decodes the held request against the count and moves words one per
// cycle under control of the sequencer.
// ----------------------------------------------------------------------------
module iol_datapath import iol_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  iol_req_t req_i,
  input  dp_cmd_t  cmd_i,
  output dp_sts_t  sts_o,
  output iol_rsp_t rsp_o
);

  logic [WordWidth-1:0]  mem_q [Capacity];
  iol_req_t              req_q;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [AddrWidth-1:0]  idx_q, idx_d;
  logic [WordWidth-1:0]  rd_a_q, rd_b_q, got_q;
  status_e               stat_q;
  iol_rsp_t              rsp_q;

  logic [PosWidth-1:0]   eff_pos;
  logic [CountWidth-1:0] cnt_m1;
  logic [AddrWidth-1:0]  top_addr, pos_addr, rd_addr, wr_addr;
  logic [WordWidth-1:0]  wr_data;
  logic                  wr_en, is_ins, is_clr, is_get;
  status_e               stat_code;

  assign cnt_m1   = cnt_q - CountWidth'(1);
  assign top_addr = cnt_m1[AddrWidth-1:0];
  assign pos_addr = eff_pos[AddrWidth-1:0];

  always_comb begin
    is_ins = 1'b0;
    is_clr = 1'b0;
    is_get = 1'b0;
    unique case (req_q.command)
      CMD_INSERT_AT: begin
        is_ins  = 1'b1;
        eff_pos = req_q.position;
      end
      CMD_PUSH_FRONT: begin
        is_ins  = 1'b1;
        eff_pos = '0;
      end
      CMD_PUSH_BACK: begin
        is_ins  = 1'b1;
        eff_pos = PosWidth'(cnt_q);
      end
      CMD_REMOVE_AT: eff_pos = req_q.position;
      CMD_GET_AT: begin
        is_get  = 1'b1;
        eff_pos = req_q.position;
      end
      CMD_POP_FRONT: eff_pos = '0;
      CMD_POP_BACK:  eff_pos = (cnt_q == '0) ? '0 : PosWidth'(cnt_m1);
      CMD_CLEAR: begin
        is_clr  = 1'b1;
        eff_pos = '0;
      end
      default: eff_pos = '0;
    endcase

    if (is_clr) begin
      stat_code = ST_OK;
    end else if (is_ins) begin
      if (eff_pos > PosWidth'(cnt_q))              stat_code = ST_RANGE;
      else if (cnt_q == CountWidth'(Capacity))     stat_code = ST_FULL;
      else                                         stat_code = ST_OK;
    end else begin
      stat_code = (eff_pos >= PosWidth'(cnt_q)) ? ST_RANGE : ST_OK;
    end
  end

  always_comb begin
    sts_o.is_ins     = is_ins;
    sts_o.is_clr     = is_clr;
    sts_o.is_get     = is_get;
    sts_o.err        = (stat_code != ST_OK);
    sts_o.ins_at_end = (eff_pos == PosWidth'(cnt_q));
    sts_o.rem_last   = (eff_pos == PosWidth'(cnt_m1));
    sts_o.idx_at_pos = (idx_q == pos_addr);
    sts_o.idx_at_top = (idx_q == top_addr);
  end

  // Read and write address selection
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_POS:     rd_addr = pos_addr;
      RD_POS_INC: rd_addr = pos_addr + AddrWidth'(1);
      RD_TOP:     rd_addr = top_addr;
      RD_DN:      rd_addr = idx_q - AddrWidth'(1);
      RD_UP:      rd_addr = idx_q + AddrWidth'(1);
      RD_ZERO:    rd_addr = '0;
      default:    rd_addr = '0;
    endcase

    wr_en   = 1'b1;
    wr_addr = pos_addr;
    wr_data = rd_a_q;
    unique case (cmd_i.wr_sel)
      WR_NONE: wr_en   = 1'b0;
      WR_UP:   wr_addr = idx_q + AddrWidth'(1);
      WR_DN:   wr_addr = idx_q - AddrWidth'(1);
      WR_WORD: wr_data = req_q.data_in;
      default: wr_en   = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_HOLD:    idx_d = idx_q;
      IDX_TOP:     idx_d = top_addr;
      IDX_POS_INC: idx_d = pos_addr + AddrWidth'(1);
      IDX_DEC:     idx_d = idx_q - AddrWidth'(1);
      IDX_INC:     idx_d = idx_q + AddrWidth'(1);
      default:     idx_d = idx_q;
    endcase

    unique case (cmd_i.cnt_op)
      CNT_HOLD: cnt_d = cnt_q;
      CNT_INC:  cnt_d = cnt_q + CountWidth'(1);
      CNT_DEC:  cnt_d = cnt_m1;
      CNT_CLR:  cnt_d = '0;
      default:  cnt_d = cnt_q;
    endcase
  end

  // Slot memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_q[rd_addr];
    rd_b_q <= mem_q[top_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.stat_load) begin
      stat_q <= stat_code;
    end
    if (cmd_i.load_req) begin
      got_q <= '0;
    end else if (cmd_i.got_load) begin
      got_q <= rd_a_q;
    end
    if (cmd_i.rsp_load) begin
      rsp_q.status        <= stat_q;
      rsp_q.data_out      <= got_q;
      rsp_q.element_count <= cnt_q;
      rsp_q.front_word    <= (cnt_q != '0) ? rd_a_q : '0;
      rsp_q.back_word     <= (cnt_q != '0) ? rd_b_q : '0;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// File: sv/iol_controller.sv
// ----------------------------------------------------------------------------
// iol_controller: sequencer for the indexed ordered list
// Accepts one request, steps the datapath through the word moves and
// holds the response until it is taken.
// ----------------------------------------------------------------------------
module iol_controller import iol_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_WRITE,
    S_READ_WAIT,
    S_REM_SHIFT,
    S_FB_READ,
    S_FB_WAIT,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_ZERO;
    cmd_o.wr_sel   = WR_NONE;
    cmd_o.idx_op   = IDX_HOLD;
    cmd_o.cnt_op   = CNT_HOLD;
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.stat_load = 1'b1;
        if (sts_i.err) begin
          state_d = S_FB_READ;
        end else if (sts_i.is_clr) begin
          cmd_o.cnt_op = CNT_CLR;
          state_d      = S_FB_READ;
        end else if (sts_i.is_ins) begin
          if (sts_i.ins_at_end) begin
            cmd_o.wr_sel = WR_WORD;
            cmd_o.cnt_op = CNT_INC;
            state_d      = S_FB_READ;
          end else begin
            cmd_o.rd_sel = RD_TOP;
            cmd_o.idx_op = IDX_TOP;
            state_d      = S_INS_SHIFT;
          end
        end else begin
          cmd_o.rd_sel = RD_POS;
          state_d      = S_READ_WAIT;
        end
      end
      S_INS_SHIFT: begin
        cmd_o.wr_sel = WR_UP;
        if (sts_i.idx_at_pos) begin
          state_d = S_INS_WRITE;
        end else begin
          cmd_o.rd_sel = RD_DN;
          cmd_o.idx_op = IDX_DEC;
        end
      end
      S_INS_WRITE: begin
        cmd_o.wr_sel = WR_WORD;
        cmd_o.cnt_op = CNT_INC;
        state_d      = S_FB_READ;
      end
      S_READ_WAIT: begin
        cmd_o.got_load = 1'b1;
        if (sts_i.is_get) begin
          state_d = S_FB_READ;
        end else if (sts_i.rem_last) begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_FB_READ;
        end else begin
          cmd_o.rd_sel = RD_POS_INC;
          cmd_o.idx_op = IDX_POS_INC;
          state_d      = S_REM_SHIFT;
        end
      end
      S_REM_SHIFT: begin
        cmd_o.wr_sel = WR_DN;
        if (sts_i.idx_at_top) begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_FB_READ;
        end else begin
          cmd_o.rd_sel = RD_UP;
          cmd_o.idx_op = IDX_INC;
        end
      end
      S_FB_READ: begin
        cmd_o.rd_sel = RD_ZERO;
        state_d      = S_FB_WAIT;
      end
      S_FB_WAIT: begin
        cmd_o.rsp_load = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list: double-ended list of words with indexed access
// Top level joining the request sequencer and the slot datapath.
// ----------------------------------------------------------------------------
// The list holds up to 64 words of 32 bits in order, position zero at the
// front, in a single-write, dual-read slot memory. It takes one request at a
// time: insert, remove or read at a position, push or pop at either end, or
// clear, and answers each request with one response carrying the status, the
// word removed or read, the new count and the front and back words. A refused
// request leaves the list as it was. Words are moved one per cycle through the
// memory's single write port, so an insert at position p costs count - p
// moves and a remove at p costs count - 1 - p moves. A refused request, a
// clear or an insert at the end goes from decode straight to the read of the
// front and back words; any other insert, and every remove or read, which
// first fetches its word, makes its moves, if any, before that read. The
// next request can be accepted in the cycle after its response leaves.
// Pushes and pops at the back, reads and clears take no moves. The memory
// needs no clearing after reset: only words at positions below the count
// ever reach a response or a move.
module indexed_ordered_list import iol_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  iol_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output iol_rsp_t out_rsp_o
);

  dp_cmd_t dp_cmd;  // sequencer to datapath
  dp_sts_t dp_sts;  // decode and index flags back to the sequencer

  // Sequence one request at a time; hold the response until taken.
  iol_controller u_iol_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // Slot memory, count and response register.
  iol_datapath u_iol_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts),
    .rsp_o  (out_rsp_o)
  );

endmodule

// File: sv/iol_checker.sv
// ----------------------------------------------------------------------------
// iol_checker: port-level checks for the indexed ordered list
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module iol_checker import iol_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input iol_req_t in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input iol_rsp_t out_rsp_o
);

  // Stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // One request in flight: busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("request accepted while another is in flight");

  // Count never exceeds capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.element_count <= CountWidth'(Capacity))
    else $error("count beyond capacity");

  // Refused requests return no data
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.data_out == '0)
    else $error("data on refused request");

  // Empty list shows zero ends
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.element_count == '0 |->
      out_rsp_o.front_word == '0 && out_rsp_o.back_word == '0)
    else $error("nonzero end word on empty list");

endmodule

bind indexed_ordered_list iol_checker u_iol_checker (.*);
